>>> hdl/q6k_pkg.sv
// ----------------------------------------------------------------------------
// q6k_pkg
// types and constants shared by the q6_k row dot-product block
// ----------------------------------------------------------------------------
`default_nettype none

package q6k_pkg;

	localparam int LANES      = 4;
	localparam int LANE_W     = $clog2(LANES);
	localparam int POS_W      = 6;
	localparam int BANK_AW    = 2;
	localparam int CODE_W     = 6;
	localparam int SCALE_W    = 8;
	localparam int ACT_W      = 16;
	localparam int HALF_W     = 16;
	localparam int QS_W       = CODE_W + SCALE_W;
	localparam int PROD_W     = QS_W + ACT_W;
	localparam int SUM4_W     = PROD_W + LANE_W;
	localparam int BLK_W      = 38;
	localparam int MANT_W     = 11;
	localparam int EXP_W      = 5;
	localparam int SCL_W      = BLK_W + MANT_W + 1;
	localparam int SHIFT_MAX  = 29;
	localparam int WIDE_W     = SCL_W - 1 + SHIFT_MAX;
	localparam int ROW_W      = 64;

	localparam logic [POS_W-1:0]   LAST_POS  = 6'd63;
	localparam logic [CODE_W-1:0]  CODE_BIAS = 6'h20;
	localparam logic [EXP_W-1:0]   EXP_SPEC  = 5'h1f;
	localparam logic [ROW_W-1:0]   ROW_MAX   = 64'h7fff_ffff_ffff_ffff;
	localparam logic [ROW_W-1:0]   ROW_MIN   = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_GROUP_SCALE = 2'd0,
		OP_BLOCK_SCALE = 2'd1,
		OP_DATA        = 2'd2
	} op_t;

	typedef logic signed [PROD_W-1:0] lane_prod_t;

	// per-beat control traveling alongside the lanes
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              row_end;
		logic [HALF_W-1:0] d_bits;
	} item_ctrl_t;

	// finished block sum heading into the scaling stages
	typedef struct packed {
		logic              valid;
		logic              row_end;
		logic [HALF_W-1:0] d_bits;
	} blk_ctrl_t;

	// scaled block contribution heading into the row accumulator
	typedef struct packed {
		logic valid;
		logic row_end;
		logic bad;
		logic clip;
	} blk_res_t;

endpackage

`default_nettype wire

>>> hdl/q6k_in_if.sv
// ----------------------------------------------------------------------------
// q6k_in_if
// input channel: scale loads and packed data beats
// ----------------------------------------------------------------------------
`default_nettype none

interface q6k_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [3:0]         scale_index;
	logic signed [7:0]  scale_value;
	logic [15:0]        half_d_bits;
	logic [7:0]         low_byte_a;
	logic [7:0]         low_byte_b;
	logic [7:0]         high_byte;
	logic signed [15:0] act0;
	logic signed [15:0] act1;
	logic signed [15:0] act2;
	logic signed [15:0] act3;
	logic               row_end;

	modport source (
		output valid, operation, scale_index, scale_value, half_d_bits,
		output low_byte_a, low_byte_b, high_byte, act0, act1, act2, act3, row_end,
		input  ready
	);
	modport sink (
		input  valid, operation, scale_index, scale_value, half_d_bits,
		input  low_byte_a, low_byte_b, high_byte, act0, act1, act2, act3, row_end,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/q6k_out_if.sv
// ----------------------------------------------------------------------------
// q6k_out_if
// output channel: one row result per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface q6k_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] row_sum;
	logic               saturated;
	logic               bad_scale;

	modport source (output valid, row_sum, saturated, bad_scale, input ready);
	modport sink (input valid, row_sum, saturated, bad_scale, output ready);
endinterface

`default_nettype wire

>>> hdl/q6k_lane.sv
// ----------------------------------------------------------------------------
// q6k_lane
// one code lane: group-scale bank, code*scale, then times activation
// ----------------------------------------------------------------------------
`default_nettype none

module q6k_lane (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic                              wr_en,
	input  wire logic [q6k_pkg::BANK_AW-1:0]       wr_addr,
	input  wire logic signed [q6k_pkg::SCALE_W-1:0] wr_data,
	input  wire logic [q6k_pkg::BANK_AW-1:0]       rd_addr,
	input  wire logic [q6k_pkg::CODE_W-1:0]        code,
	input  wire logic signed [q6k_pkg::ACT_W-1:0]  act,
	output q6k_pkg::lane_prod_t                    prod
);
	import q6k_pkg::*;

	logic signed [SCALE_W-1:0] bank [2**BANK_AW];
	logic signed [SCALE_W-1:0] sc_s1;
	logic signed [CODE_W-1:0]  q_s1;
	logic signed [ACT_W-1:0]   act_s1;
	logic signed [ACT_W-1:0]   act_s2;
	logic signed [QS_W-1:0]    qs_s2;
	lane_prod_t                prod_s3;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bank[wr_addr] <= wr_data;
		end
	end

	// flipping the top bit gives code - 32 as a signed 6-bit value
	always_ff @(posedge clk) begin
		if (en) begin
			sc_s1   <= bank[rd_addr];
			q_s1    <= signed'(code ^ CODE_BIAS);
			act_s1  <= act;
			qs_s2   <= QS_W'(q_s1 * sc_s1);
			act_s2  <= act_s1;
			prod_s3 <= PROD_W'(qs_s2 * act_s2);
		end
	end

	assign prod = prod_s3;
endmodule

`default_nettype wire

>>> hdl/q6k_merge.sv
// ----------------------------------------------------------------------------
// q6k_merge
// adds the lane products and accumulates the exact block sum
// ----------------------------------------------------------------------------
`default_nettype none

module q6k_merge (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  q6k_pkg::item_ctrl_t               ctrl,
	input  q6k_pkg::lane_prod_t               prod [q6k_pkg::LANES],
	output q6k_pkg::blk_ctrl_t                blk,
	output logic signed [q6k_pkg::BLK_W-1:0]  blk_sum
);
	import q6k_pkg::*;

	logic signed [SUM4_W-1:0] sum4;
	logic signed [SUM4_W-1:0] sum_s4;
	item_ctrl_t               ctrl_s4;
	logic signed [BLK_W-1:0]  partial_q;
	logic signed [BLK_W-1:0]  total;
	logic signed [BLK_W-1:0]  sum_s5;
	blk_ctrl_t                blk_s5;

	always_comb begin
		sum4 = '0;
		for (int k = 0; k < LANES; k++) begin
			sum4 = sum4 + SUM4_W'(prod[k]);
		end
	end

	assign total = partial_q + BLK_W'(sum_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4   <= '0;
			blk_s5    <= '0;
			partial_q <= '0;
		end else if (en) begin
			ctrl_s4        <= ctrl;
			blk_s5.valid   <= ctrl_s4.valid & ctrl_s4.last;
			blk_s5.row_end <= ctrl_s4.row_end;
			blk_s5.d_bits  <= ctrl_s4.d_bits;
			if (ctrl_s4.valid) begin
				partial_q <= ctrl_s4.last ? '0 : total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= sum4;
			if (ctrl_s4.valid & ctrl_s4.last) begin
				sum_s5 <= total;
			end
		end
	end

	assign blk     = blk_s5;
	assign blk_sum = sum_s5;
endmodule

`default_nettype wire

>>> hdl/q6k_scale.sv
// ----------------------------------------------------------------------------
// q6k_scale
// multiplies a block sum by its half-precision scale, saturating to q32.32
// ----------------------------------------------------------------------------
`default_nettype none

module q6k_scale (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  q6k_pkg::blk_ctrl_t                blk,
	input  wire logic signed [q6k_pkg::BLK_W-1:0] blk_sum,
	output q6k_pkg::blk_res_t                 res,
	output logic [q6k_pkg::ROW_W-1:0]         res_val
);
	import q6k_pkg::*;

	logic [EXP_W-1:0]        exp_f;
	logic [MANT_W-1:0]       mant;
	logic signed [SCL_W-1:0] p_s6;
	logic [EXP_W-1:0]        sh_s6;
	logic                    dneg_s6;
	logic                    bad_s6;
	logic                    valid_s6;
	logic                    row_end_s6;

	logic                    neg;
	logic [SCL_W-1:0]        p_abs;
	logic [WIDE_W-1:0]       wide;
	logic                    hi_nz;
	logic                    low_nz;
	logic                    over;
	logic [ROW_W-1:0]        val;
	blk_res_t                res_s7;
	logic [ROW_W-1:0]        val_s7;

	assign exp_f = blk.d_bits[14:10];
	assign mant  = (exp_f == '0) ? {1'b0, blk.d_bits[9:0]} : {1'b1, blk.d_bits[9:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			res_s7   <= '0;
		end else if (en) begin
			valid_s6       <= blk.valid;
			res_s7.valid   <= valid_s6;
			res_s7.row_end <= row_end_s6;
			res_s7.bad     <= bad_s6;
			res_s7.clip    <= ~bad_s6 & over;
		end
	end

	// subnormals use exponent one without the hidden bit, so shift is e - 1 or 0
	always_ff @(posedge clk) begin
		if (en) begin
			p_s6       <= blk_sum * signed'({1'b0, mant});
			sh_s6      <= (exp_f == '0) ? '0 : exp_f - 1'b1;
			dneg_s6    <= blk.d_bits[15];
			bad_s6     <= (exp_f == EXP_SPEC);
			row_end_s6 <= blk.row_end;
			val_s7     <= bad_s6 ? '0 : val;
		end
	end

	always_comb begin
		neg    = p_s6[SCL_W-1] ^ dneg_s6;
		p_abs  = p_s6[SCL_W-1] ? SCL_W'(-p_s6) : p_s6;
		wide   = WIDE_W'(p_abs) << sh_s6;
		hi_nz  = |wide[WIDE_W-1:ROW_W];
		low_nz = |wide[ROW_W-2:0];
		// a negative result may reach exactly -2^63
		over   = neg ? (hi_nz | (wide[ROW_W-1] & low_nz)) : (hi_nz | wide[ROW_W-1]);
		if (over) begin
			val = neg ? ROW_MIN : ROW_MAX;
		end else if (neg) begin
			val = -wide[ROW_W-1:0];
		end else begin
			val = wide[ROW_W-1:0];
		end
	end

	assign res     = res_s7;
	assign res_val = val_s7;
endmodule

`default_nettype wire

>>> hdl/q6k_rowacc.sv
// ----------------------------------------------------------------------------
// q6k_rowacc
// saturating row accumulator and result output register
// ----------------------------------------------------------------------------
`default_nettype none

module q6k_rowacc (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  q6k_pkg::blk_res_t              res,
	input  wire logic [q6k_pkg::ROW_W-1:0] res_val,
	output logic                           stall,
	q6k_out_if.source                      result
);
	import q6k_pkg::*;

	logic [ROW_W-1:0] acc_q;
	logic             clip_q;
	logic             bad_q;
	logic [ROW_W:0]   sum;
	logic             add_over;
	logic [ROW_W-1:0] acc_new;
	logic             clip_new;
	logic             bad_new;
	logic             take;
	logic             load;
	logic             out_valid_q;
	logic [ROW_W-1:0] sum_q;
	logic             sat_q;
	logic             badf_q;

	assign sum      = {acc_q[ROW_W-1], acc_q} + {res_val[ROW_W-1], res_val};
	assign add_over = sum[ROW_W] ^ sum[ROW_W-1];
	assign acc_new  = add_over ? (sum[ROW_W] ? ROW_MIN : ROW_MAX) : sum[ROW_W-1:0];
	assign clip_new = clip_q | res.clip | add_over;
	assign bad_new  = bad_q | res.bad;

	// hold the whole pipeline while a finished row cannot enter a full output
	assign stall = res.valid & res.row_end & out_valid_q & ~result.ready;
	assign take  = res.valid & ~stall;
	assign load  = take & res.row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			clip_q      <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				acc_q  <= res.row_end ? '0 : acc_new;
				clip_q <= res.row_end ? 1'b0 : clip_new;
				bad_q  <= res.row_end ? 1'b0 : bad_new;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_q  <= acc_new;
			sat_q  <= clip_new;
			badf_q <= bad_new;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.row_sum   = signed'(sum_q);
	assign result.saturated = sat_q;
	assign result.bad_scale = badf_q;
endmodule

`default_nettype wire

>>> hdl/q6k_dequant_dot_row_top.sv
// ----------------------------------------------------------------------------
// q6k_dequant_dot_row_top
// 6-bit blocked quantized weight row times q8.8 activation vector
// ----------------------------------------------------------------------------
// item channel: valid/ready beats. operation group-scale and block-scale beats
// load the 16 group scales and the half-precision block scale; data beats
// carry four codes and four activations. a block is 64 data beats; row_end on
// the 64th beat of a block closes the row and produces one result beat.
// result channel: valid/ready, row_sum (q32.32, saturated) with flags.
// throughput: one beat per cycle while the pipeline is not stalled; four lanes handle the four
// codes of a beat side by side, each owning a 4-entry slice of the scales.
// path: after the closing data beat is taken, the result passes through the
// bank read, two multiplier stages, lane merge, block sum, fp16 multiply,
// shift/saturate and row accumulate stages into the output register.
// stall: a finished result waits in the output register while input keeps
// flowing; only when the next row closes while that result is still unread
// does ready drop and the whole pipeline hold until the receiver takes it.
// reset: clears position, sums, flags and valid bits; scales stay unknown
// until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module q6k_dequant_dot_row_top (
	input  wire logic clk,
	input  wire logic arst_n,
	q6k_in_if.sink    item,
	q6k_out_if.source result
);
	import q6k_pkg::*;

	logic                     en;
	logic                     stall;
	logic                     accept;
	logic                     take_data;
	logic                     take_gs;
	logic                     take_bs;
	logic [POS_W-1:0]         pos_q;
	logic [HALF_W-1:0]        block_scale_q;
	item_ctrl_t               ctrl_s1;
	item_ctrl_t               ctrl_s2;
	item_ctrl_t               ctrl_s3;
	logic [CODE_W-1:0]        code [LANES];
	logic signed [ACT_W-1:0]  act [LANES];
	lane_prod_t               prod [LANES];
	blk_ctrl_t                blk;
	logic signed [BLK_W-1:0]  blk_sum;
	blk_res_t                 res;
	logic [ROW_W-1:0]         res_val;

	assign en         = ~stall;
	assign item.ready = en;
	assign accept     = item.valid & en;

	always_comb begin
		take_data = 1'b0;
		take_gs   = 1'b0;
		take_bs   = 1'b0;
		unique case (op_t'(item.operation))
			OP_GROUP_SCALE: take_gs   = accept;
			OP_BLOCK_SCALE: take_bs   = accept;
			OP_DATA:        take_data = accept;
			default:        ;
		endcase
	end

	// rebuild the four 6-bit codes: low nibble plus a 2-bit high part each
	always_comb begin
		code[0] = {item.high_byte[1:0], item.low_byte_a[3:0]};
		code[1] = {item.high_byte[3:2], item.low_byte_b[3:0]};
		code[2] = {item.high_byte[5:4], item.low_byte_a[7:4]};
		code[3] = {item.high_byte[7:6], item.low_byte_b[7:4]};
		act[0]  = item.act0;
		act[1]  = item.act1;
		act[2]  = item.act2;
		act[3]  = item.act3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			if (take_data) begin
				pos_q <= pos_q + 1'b1;
			end
			ctrl_s1.valid   <= take_data;
			ctrl_s1.last    <= (pos_q == LAST_POS);
			ctrl_s1.row_end <= item.row_end;
			ctrl_s1.d_bits  <= block_scale_q;
			ctrl_s2         <= ctrl_s1;
			ctrl_s3         <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_bs) begin
			block_scale_q <= item.half_d_bits;
		end
	end

	// scale index bits [2:1] pick the lane, bits 3 and 0 the bank entry;
	// a data beat reads entry pos[5:4], the top two bits of the block position
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		q6k_lane u_lane (
			.clk     (clk),
			.en      (en),
			.wr_en   (take_gs & (item.scale_index[2:1] == LANE_W'(k))),
			.wr_addr ({item.scale_index[3], item.scale_index[0]}),
			.wr_data (item.scale_value),
			.rd_addr (pos_q[POS_W-1:POS_W-BANK_AW]),
			.code    (code[k]),
			.act     (act[k]),
			.prod    (prod[k])
		);
	end

	q6k_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctrl    (ctrl_s3),
		.prod    (prod),
		.blk     (blk),
		.blk_sum (blk_sum)
	);

	q6k_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.blk     (blk),
		.blk_sum (blk_sum),
		.res     (res),
		.res_val (res_val)
	);

	q6k_rowacc u_rowacc (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.res_val (res_val),
		.stall   (stall),
		.result  (result)
	);
endmodule

`default_nettype wire

>>> hdl/q6k_checker.sv
// ----------------------------------------------------------------------------
// q6k_checker
// port-level checks for the q6_k row dot-product block
// ----------------------------------------------------------------------------
`default_nettype none

module q6k_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] out_sum,
	input wire logic        out_sat,
	input wire logic        out_bad
);
	// no result beat is offered while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// input back-pressure only comes from an unread result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without result back-pressure");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result beat dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(out_sum) && $stable(out_sat) && $stable(out_bad)))
		else $error("result beat changed while stalled");
endmodule

bind q6k_dequant_dot_row_top q6k_checker u_q6k_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_sum   (result.row_sum),
	.out_sat   (result.saturated),
	.out_bad   (result.bad_scale)
);

`default_nettype wire
